/* sv/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, register indexes and fixed-point helpers for the bisection
// root finder.
// ----------------------------------------------------------------------------
package brf_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WORD_W            = 32;
   localparam int TOL_W             = 31;
   localparam int ITER_W            = 8;
   localparam int CSR_INDEX_W       = 3;
   localparam int REQ_DATA_W        = 64;
   localparam int RSP_DATA_W        = 80;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   // integer parts of the reset coefficients
   localparam longint RESET_K_FOUR  = 600;
   localparam longint RESET_K_THREE = -550;
   localparam longint RESET_K_TWO   = 200;
   localparam longint RESET_K_ONE   = -20;
   localparam longint RESET_K_ZERO  = -1;
   localparam int     TOL_DIVISOR   = 100;
   localparam logic [ITER_W-1:0] RESET_ITER_LIMIT = 8'd50;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_COEF_FOUR  = 3'd0,
      REG_COEF_THREE = 3'd1,
      REG_COEF_TWO   = 3'd2,
      REG_COEF_ONE   = 3'd3,
      REG_COEF_ZERO  = 3'd4,
      REG_TOLERANCE  = 3'd5,
      REG_ITER_LIMIT = 3'd6,
      REG_TARGET     = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MID,
      ST_EVAL,
      ST_DRAIN,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] coef_four;
      logic signed [WORD_W-1:0] coef_three;
      logic signed [WORD_W-1:0] coef_two;
      logic signed [WORD_W-1:0] coef_one;
      logic signed [WORD_W-1:0] coef_zero;
      logic        [TOL_W-1:0]  tolerance;
      logic        [ITER_W-1:0] iteration_limit;
      logic signed [WORD_W-1:0] target_value;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic       load;       // take a new start interval
      logic       mid;        // form the midpoint
      logic       mul;        // issue one horner multiply
      logic [1:0] step;       // horner step of that multiply
      logic       sel_left;   // multiply is for the left end, else midpoint
      logic       advance;    // count up and move one end
      logic       mark;       // record the end of the search
      logic       mark_conv;  // converged flag recorded with mark
      logic       rsp_load;   // move the answer into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic within_tol;
      logic below_limit;
      logic out_free;
   } status_type;

   function automatic logic signed [WORD_W-1:0] sat32(input longint v);
      logic signed [WORD_W-1:0] r;
      if (v > S32_MAX) begin
         r = WORD_W'(S32_MAX);
      end else if (v < S32_MIN) begin
         r = WORD_W'(S32_MIN);
      end else begin
         r = WORD_W'(v);
      end
      return r;
   endfunction

   function automatic logic signed [WORD_W-1:0] fix_int(input longint k, input int frac);
      longint v;
      v = k <<< frac;
      return sat32(v);
   endfunction

endpackage

/* sv/brf_regs.sv */
// ----------------------------------------------------------------------------
// brf_regs
// Configuration register file: coefficients, tolerance, iteration limit and
// target value, written through the csr channel.
// ----------------------------------------------------------------------------
module brf_regs #(
   parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [brf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [brf_pkg::WORD_W-1:0]          csr_data,
   output brf_pkg::cfg_type                    cfg
);
   import brf_pkg::*;

   localparam logic signed [WORD_W-1:0] RST_FOUR  = fix_int(RESET_K_FOUR, FRAC_BITS);
   localparam logic signed [WORD_W-1:0] RST_THREE = fix_int(RESET_K_THREE, FRAC_BITS);
   localparam logic signed [WORD_W-1:0] RST_TWO   = fix_int(RESET_K_TWO, FRAC_BITS);
   localparam logic signed [WORD_W-1:0] RST_ONE   = fix_int(RESET_K_ONE, FRAC_BITS);
   localparam logic signed [WORD_W-1:0] RST_ZERO  = fix_int(RESET_K_ZERO, FRAC_BITS);
   localparam longint                   RST_TOL_L = (64'sd1 <<< FRAC_BITS) / TOL_DIVISOR;
   localparam logic [TOL_W-1:0]         RST_TOL   = TOL_W'(RST_TOL_L);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_COEF_FOUR:  cfg_in.coef_four       = csr_data;
            REG_COEF_THREE: cfg_in.coef_three      = csr_data;
            REG_COEF_TWO:   cfg_in.coef_two        = csr_data;
            REG_COEF_ONE:   cfg_in.coef_one        = csr_data;
            REG_COEF_ZERO:  cfg_in.coef_zero       = csr_data;
            REG_TOLERANCE:  cfg_in.tolerance       = csr_data[TOL_W-1:0];
            REG_ITER_LIMIT: cfg_in.iteration_limit = csr_data[ITER_W-1:0];
            REG_TARGET:     cfg_in.target_value    = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_four       <= RST_FOUR;
         cfg_ff.coef_three      <= RST_THREE;
         cfg_ff.coef_two        <= RST_TWO;
         cfg_ff.coef_one        <= RST_ONE;
         cfg_ff.coef_zero       <= RST_ZERO;
         cfg_ff.tolerance       <= RST_TOL;
         cfg_ff.iteration_limit <= RESET_ITER_LIMIT;
         cfg_ff.target_value    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/brf_ctrl.sv */
// ----------------------------------------------------------------------------
// brf_ctrl
// Sequencer of the bisection search: midpoint, interleaved horner multiplies
// for the midpoint and the left end, tolerance check and result hand-off.
// ----------------------------------------------------------------------------
module brf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  brf_pkg::status_type status,
   output brf_pkg::cmd_type    cmd
);
   import brf_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.step     = cnt_ff[2:1];
      cmd.sel_left = cnt_ff[0];
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            cmd.mid  = 1'b1;
            cnt_in   = '0;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // even slots multiply for the midpoint, odd slots for the left end
            cmd.mul = 1'b1;
            cnt_in  = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.below_limit && status.within_tol) begin
               cmd.mark      = 1'b1;
               cmd.mark_conv = 1'b1;
               state_in      = ST_FINISH;
            end else if (status.below_limit) begin
               cmd.advance = 1'b1;
               state_in    = ST_MID;
            end else begin
               cmd.mark = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/brf_dpath.sv */
// ----------------------------------------------------------------------------
// brf_dpath
// Datapath: interval registers, shared 32x32 multiplier with a registered
// product, saturating horner add stage, tolerance and limit compares and the
// output register.
// ----------------------------------------------------------------------------
module brf_dpath #(
   parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  brf_pkg::cfg_type                    cfg,
   input  brf_pkg::cmd_type                    cmd,
   output brf_pkg::status_type                 status,
   input  logic [brf_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [brf_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import brf_pkg::*;

   localparam int PAD_W = RSP_DATA_W - 3 * WORD_W + WORD_W - ITER_W - 1;

   logic signed [WORD_W-1:0] a_ff, b_ff, p_ff, fp_ff, fa_ff;
   logic        [ITER_W-1:0] n_ff;
   logic                     conv_ff;
   logic signed [2*WORD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic                     prod_left_ff;
   logic [1:0]               prod_step_ff;

   logic signed [WORD_W-1:0] rsp_root_ff, rsp_value_ff;
   logic        [ITER_W-1:0] rsp_iter_ff;
   logic                     rsp_conv_ff;
   logic                     rsp_valid_ff;

   logic signed [WORD_W:0]     mid_sum;
   logic signed [WORD_W-1:0]   mul_a, mul_x;
   logic signed [2*WORD_W-1:0] prod_in;
   logic signed [2*WORD_W-1:0] prod_shr;
   logic signed [WORD_W-1:0]   prod_sat, add_coef, horner_in;
   logic signed [WORD_W:0]     add_sum;
   logic signed [WORD_W:0]     diff, tol_pos, tol_neg;
   logic                       fa_above, fa_below, fp_above, fp_below, same_side;

   // midpoint without overflow, floor of the halved sum
   assign mid_sum = {a_ff[WORD_W-1], a_ff} + {b_ff[WORD_W-1], b_ff};

   // multiply stage: first step starts from the leading coefficient
   assign mul_x   = cmd.sel_left ? a_ff : p_ff;
   assign mul_a   = (cmd.step == 2'd0) ? cfg.coef_four : (cmd.sel_left ? fa_ff : fp_ff);
   assign prod_in = mul_a * mul_x;

   // add stage on the registered product
   always_comb begin
      case (prod_step_ff)
         2'd0:    add_coef = cfg.coef_three;
         2'd1:    add_coef = cfg.coef_two;
         2'd2:    add_coef = cfg.coef_one;
         default: add_coef = cfg.coef_zero;
      endcase
   end

   assign prod_shr  = prod_ff >>> FRAC_BITS;
   assign prod_sat  = sat32(prod_shr);
   assign add_sum   = {prod_sat[WORD_W-1], prod_sat} + {add_coef[WORD_W-1], add_coef};
   assign horner_in = sat32({{(WORD_W-1){add_sum[WORD_W]}}, add_sum});

   // exact distance to target against the strict tolerance bound
   assign diff    = {fp_ff[WORD_W-1], fp_ff} -
                    {cfg.target_value[WORD_W-1], cfg.target_value};
   assign tol_pos = {2'b00, cfg.tolerance};
   assign tol_neg = -tol_pos;

   assign fa_above  = fa_ff > cfg.target_value;
   assign fa_below  = fa_ff < cfg.target_value;
   assign fp_above  = fp_ff > cfg.target_value;
   assign fp_below  = fp_ff < cfg.target_value;
   assign same_side = (fa_above && fp_above) || (fa_below && fp_below);

   assign status.within_tol  = (diff > tol_neg) && (diff < tol_pos);
   assign status.below_limit = n_ff < cfg.iteration_limit;
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= req_tdata[WORD_W-1:0];
         b_ff <= req_tdata[2*WORD_W-1:WORD_W];
         n_ff <= ITER_W'(1);
      end else if (cmd.advance) begin
         n_ff <= n_ff + ITER_W'(1);
         if (same_side) begin
            a_ff <= p_ff;
         end else begin
            b_ff <= p_ff;
         end
      end
      if (cmd.mid) begin
         p_ff <= mid_sum[WORD_W:1];
      end
      if (cmd.mul) begin
         prod_ff      <= prod_in;
         prod_left_ff <= cmd.sel_left;
         prod_step_ff <= cmd.step;
      end
      if (prod_vld_ff) begin
         if (prod_left_ff) begin
            fa_ff <= horner_in;
         end else begin
            fp_ff <= horner_in;
         end
      end
      if (cmd.mark) begin
         conv_ff <= cmd.mark_conv;
      end
      if (cmd.rsp_load) begin
         rsp_root_ff  <= p_ff;
         rsp_value_ff <= fp_ff;
         rsp_iter_ff  <= n_ff;
         rsp_conv_ff  <= conv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_conv_ff, rsp_iter_ff, rsp_value_ff, rsp_root_ff};

   // a finished answer never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten while a result waits");

   // a converged answer lies strictly within tolerance of the target
   assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && conv_ff) |-> status.within_tol)
      else $error("converged flag set outside tolerance");

   // the count never runs past the limit, save a first pass under a zero limit
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (n_ff <= cfg.iteration_limit || n_ff == ITER_W'(1)))
      else $error("iteration count beyond limit");

   // no step update while a horner add is still in flight
   assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> !prod_vld_ff)
      else $error("interval moved during evaluation");

endmodule

/* sv/bisection_root_finder.sv */
// ----------------------------------------------------------------------------
// bisection_root_finder
// Bisection search for the point where a configurable quartic in Q16.16
// meets a target value; one result per start interval.
// ----------------------------------------------------------------------------
// Passes: the search runs n passes, n being iterations_used (1..255); each
//   pass is a midpoint step, the horner multiplies on the shared multiplier
//   (four horner steps for midpoint and left end, interleaved), an add drain
//   step and a check step.
// Throughput: one item at a time; the next req transfer is taken once the
//   answer has moved into the output register.
// Reset: synchronous; control and csr registers reset, no result pending.
module bisection_root_finder #(
   parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // left_end [31:0], right_end [63:32]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [brf_pkg::REQ_DATA_W-1:0]      req_tdata,
   // root_estimate [31:0], value_at_root [63:32], iterations_used [71:64],
   // converged [72], zero fill above
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [brf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [brf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [brf_pkg::WORD_W-1:0]          csr_data
);
   import brf_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   brf_regs #(
      .FRAC_BITS (FRAC_BITS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   brf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   brf_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
